// ===== design/mtpc_pkg.sv =====
// Shared types and constants for the motor tacho position controller.
package mtpc_pkg;

	typedef logic [2:0] opcode_t;
	typedef logic [1:0] pin_drive_t;

	localparam opcode_t OP_TACHO = 3'd0;
	localparam opcode_t OP_MOVE  = 3'd1;
	localparam opcode_t OP_POWER = 3'd2;
	localparam opcode_t OP_COUNT = 3'd3;
	localparam opcode_t OP_BRAKE = 3'd4;

	localparam pin_drive_t PIN_LOW  = 2'd0;
	localparam pin_drive_t PIN_HIGH = 2'd1;
	localparam pin_drive_t PIN_FREE = 2'd2;

	localparam int POWER_MAX  = 100;
	localparam int DUTY_FULL  = 5500;
	localparam int DUTY_STEP  = 55;
	localparam int DUTY_W     = 13;
	localparam int MAG_W      = 7;

	typedef struct packed {
		opcode_t            opcode;
		logic [1:0]         port;
		logic               tacho_level;
		logic               tacho_dir;
		logic               brake;
		logic signed [31:0] value;
		logic signed [15:0] speed;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         port_out;
		logic [DUTY_W-1:0]  duty;
		pin_drive_t         pin_a_drive;
		pin_drive_t         pin_b_drive;
		logic signed [31:0] position;
		logic               target_hit;
	} rsp_item_t;

	typedef struct packed {
		logic             zero;
		logic             neg;
		logic [MAG_W-1:0] mag;
		logic             brake;
	} power_req_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		pin_drive_t        pin_a;
		pin_drive_t        pin_b;
	} power_drive_t;

endpackage

// ===== design/mtpc_if.sv =====
// Valid/ready channel interfaces for command and response transactions.
interface mtpc_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [1:0]         port;
	logic               tacho_level;
	logic               tacho_dir;
	logic               brake;
	logic signed [31:0] value;
	logic signed [15:0] speed;

	modport source (output valid, opcode, port, tacho_level, tacho_dir, brake, value, speed,
		input ready);
	modport sink (input valid, opcode, port, tacho_level, tacho_dir, brake, value, speed,
		output ready);
endinterface

interface mtpc_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         port_out;
	logic [12:0]        duty;
	logic [1:0]         pin_a_drive;
	logic [1:0]         pin_b_drive;
	logic signed [31:0] position;
	logic               target_hit;

	modport source (output valid, port_out, duty, pin_a_drive, pin_b_drive, position,
		target_hit, input ready);
	modport sink (input valid, port_out, duty, pin_a_drive, pin_b_drive, position,
		target_hit, output ready);
endinterface

// ===== design/motor_tacho_position_controller.sv =====
// Top level of the motor tacho position controller: input register, port state, result register.
//
//  channel  dir  transaction carries
//  cmd      in   opcode, port, tacho_level, tacho_dir, brake, value, speed
//  rsp      out  port_out, duty, pin_a_drive, pin_b_drive, position, target_hit
//
// One command is accepted per cycle unless both stages are full; responses come from rsp_q.
// The per-port state is read for the item in the input register and written as it advances,
// so back-to-back commands to the same port see each other's updates.
// Reset clears all port state and empties both register stages.
// A stalled response holds the result register; the input register keeps accepting
// until both stages are full.
module motor_tacho_position_controller #(
	parameter int PORT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	mtpc_cmd_if.sink    cmd,
	mtpc_rsp_if.source  rsp
);

	mtpc_pkg::cmd_item_t item_s1;
	logic                valid_s1;
	mtpc_pkg::rsp_item_t result;
	mtpc_pkg::rsp_item_t rsp_q;
	logic                rsp_valid_q;
	logic                advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd.ready)
			valid_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.opcode      <= cmd.opcode;
			item_s1.port        <= cmd.port;
			item_s1.tacho_level <= cmd.tacho_level;
			item_s1.tacho_dir   <= cmd.tacho_dir;
			item_s1.brake       <= cmd.brake;
			item_s1.value       <= cmd.value;
			item_s1.speed       <= cmd.speed;
		end
	end

	mtpc_core #(
		.PORT_COUNT (PORT_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.update (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (!rsp_valid_q || rsp.ready)
			rsp_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			rsp_q <= result;
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.port_out    = rsp_q.port_out;
	assign rsp.duty        = rsp_q.duty;
	assign rsp.pin_a_drive = rsp_q.pin_a_drive;
	assign rsp.pin_b_drive = rsp_q.pin_b_drive;
	assign rsp.position    = rsp_q.position;
	assign rsp.target_hit  = rsp_q.target_hit;

	a_hit_pins_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.target_hit |->
			rsp.pin_a_drive == rsp.pin_b_drive && rsp.pin_a_drive != mtpc_pkg::PIN_FREE)
		else $error("target hit without off pins");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.duty <= mtpc_pkg::DUTY_W'(mtpc_pkg::DUTY_FULL + 1))
		else $error("duty above the full-scale compare value");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> valid_s1 && rsp_valid_q && !rsp.ready)
		else $error("input stalled while a stage is free");

	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid_q)
		else $error("advanced item did not reach the result register");

endmodule

// ===== design/mtpc_power_map.sv =====
// Maps a clamped signed power to the PWM compare value and drive pin states.
module mtpc_power_map (
	input  mtpc_pkg::power_req_t   req,
	output mtpc_pkg::power_drive_t drive
);

	logic [mtpc_pkg::DUTY_W-1:0] step;

	assign step = mtpc_pkg::DUTY_W'(req.mag) * mtpc_pkg::DUTY_W'(mtpc_pkg::DUTY_STEP);

	always_comb begin
		if (req.zero) begin
			drive.duty  = '0;
			drive.pin_a = req.brake ? mtpc_pkg::PIN_HIGH : mtpc_pkg::PIN_LOW;
			drive.pin_b = req.brake ? mtpc_pkg::PIN_HIGH : mtpc_pkg::PIN_LOW;
		end else begin
			drive.duty = mtpc_pkg::DUTY_W'(mtpc_pkg::DUTY_FULL + 1) - step;
			if (req.neg) begin
				drive.pin_a = mtpc_pkg::PIN_LOW;
				drive.pin_b = mtpc_pkg::PIN_FREE;
			end else begin
				drive.pin_a = mtpc_pkg::PIN_FREE;
				drive.pin_b = mtpc_pkg::PIN_LOW;
			end
		end
	end

endmodule

// ===== design/mtpc_core.sv =====
// Per-port state registers with the single-pass read-modify-write update.
module mtpc_core #(
	parameter int PORT_COUNT = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  update,
	input  mtpc_pkg::cmd_item_t   item,
	output mtpc_pkg::rsp_item_t   result
);

	localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

	logic [31:0]                 count_q     [PORT_COUNT];
	logic [31:0]                 target_q    [PORT_COUNT];
	logic                        level_q     [PORT_COUNT];
	logic                        brake_q     [PORT_COUNT];
	logic [mtpc_pkg::DUTY_W-1:0] duty_q      [PORT_COUNT];
	mtpc_pkg::pin_drive_t        pin_a_q     [PORT_COUNT];
	mtpc_pkg::pin_drive_t        pin_b_q     [PORT_COUNT];

	logic [IDX_W-1:0]            idx;
	logic                        port_ok;
	logic [31:0]                 cnt;
	logic [31:0]                 tgt;
	logic                        brk;
	logic [31:0]                 cnt_nx;
	logic [31:0]                 tgt_nx;
	logic                        lvl_nx;
	logic                        brk_nx;
	logic [mtpc_pkg::DUTY_W-1:0] duty_nx;
	mtpc_pkg::pin_drive_t        pin_a_nx;
	mtpc_pkg::pin_drive_t        pin_b_nx;
	logic                        hit;
	logic                        apply;
	logic                        moving;
	logic signed [15:0]          clamped;
	logic [15:0]                 abs_clamped;
	logic [31:0]                 stepped;
	mtpc_pkg::power_req_t        preq;
	mtpc_pkg::power_drive_t      pdrv;

	assign idx     = IDX_W'(item.port);
	assign port_ok = 32'(item.port) < PORT_COUNT;
	assign cnt     = count_q[idx];
	assign tgt     = target_q[idx];
	assign brk     = brake_q[idx];
	assign moving  = (item.opcode == mtpc_pkg::OP_MOVE);

	always_comb begin
		if (item.speed > 16'(mtpc_pkg::POWER_MAX))
			clamped = 16'(mtpc_pkg::POWER_MAX);
		else if (item.speed < -16'sd100)
			clamped = -16'sd100;
		else
			clamped = item.speed;
		abs_clamped = clamped[15] ? -clamped : clamped;
	end

	always_comb begin
		preq.mag   = mtpc_pkg::MAG_W'(abs_clamped);
		preq.brake = moving ? item.brake : brk;
		if (moving) begin
			preq.neg  = item.value[31];
			preq.zero = (item.value == '0) || (abs_clamped == '0);
		end else begin
			preq.neg  = clamped[15];
			preq.zero = (clamped == '0);
		end
	end

	mtpc_power_map u_power_map (
		.req   (preq),
		.drive (pdrv)
	);

	assign stepped = (item.tacho_level != item.tacho_dir) ? cnt + 32'd1 : cnt - 32'd1;

	always_comb begin
		cnt_nx   = cnt;
		tgt_nx   = tgt;
		lvl_nx   = level_q[idx];
		brk_nx   = brk;
		duty_nx  = duty_q[idx];
		pin_a_nx = pin_a_q[idx];
		pin_b_nx = pin_b_q[idx];
		hit      = 1'b0;
		apply    = 1'b0;
		case (item.opcode)
			mtpc_pkg::OP_TACHO: begin
				if (item.tacho_level != level_q[idx]) begin
					cnt_nx = stepped;
					lvl_nx = item.tacho_level;
					if (stepped == tgt) begin
						hit      = 1'b1;
						pin_a_nx = brk ? mtpc_pkg::PIN_HIGH : mtpc_pkg::PIN_LOW;
						pin_b_nx = brk ? mtpc_pkg::PIN_HIGH : mtpc_pkg::PIN_LOW;
					end
				end
			end
			mtpc_pkg::OP_MOVE: begin
				tgt_nx = cnt + item.value;
				brk_nx = item.brake;
				apply  = 1'b1;
			end
			mtpc_pkg::OP_POWER: apply  = 1'b1;
			mtpc_pkg::OP_COUNT: cnt_nx = item.value;
			mtpc_pkg::OP_BRAKE: brk_nx = item.brake;
			default: ;
		endcase
		if (apply) begin
			duty_nx  = pdrv.duty;
			pin_a_nx = pdrv.pin_a;
			pin_b_nx = pdrv.pin_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_COUNT; i++) begin
				count_q[i]  <= '0;
				target_q[i] <= '0;
				level_q[i]  <= 1'b0;
				brake_q[i]  <= 1'b0;
				duty_q[i]   <= '0;
				pin_a_q[i]  <= mtpc_pkg::PIN_FREE;
				pin_b_q[i]  <= mtpc_pkg::PIN_FREE;
			end
		end else if (update && port_ok) begin
			count_q[idx]  <= cnt_nx;
			target_q[idx] <= tgt_nx;
			level_q[idx]  <= lvl_nx;
			brake_q[idx]  <= brk_nx;
			duty_q[idx]   <= duty_nx;
			pin_a_q[idx]  <= pin_a_nx;
			pin_b_q[idx]  <= pin_b_nx;
		end
	end

	always_comb begin
		result.port_out = item.port;
		if (port_ok) begin
			result.duty        = duty_nx;
			result.pin_a_drive = pin_a_nx;
			result.pin_b_drive = pin_b_nx;
			result.position    = cnt_nx;
			result.target_hit  = hit;
		end else begin
			result.duty        = '0;
			result.pin_a_drive = mtpc_pkg::PIN_FREE;
			result.pin_b_drive = mtpc_pkg::PIN_FREE;
			result.position    = '0;
			result.target_hit  = 1'b0;
		end
	end

endmodule
